@@ design/amu_pkg.sv @@
package amu_pkg;

	localparam int ModeW = 4;
	localparam int AddrW = 16;
	localparam int ByteW = 8;
	localparam int KindW = 2;
	localparam int InDataW = 48;
	localparam int OutDataW = 48;

	typedef enum logic [KindW-1:0] {
		RK_READ    = 2'd0,
		RK_DONE    = 2'd1,
		RK_IGNORED = 2'd2
	} result_kind_t;

	typedef enum logic [ModeW-1:0] {
		M_IMP = 4'd0,
		M_IMM = 4'd1,
		M_ZP  = 4'd2,
		M_ZPX = 4'd3,
		M_ZPY = 4'd4,
		M_ABS = 4'd5,
		M_ABX = 4'd6,
		M_ABY = 4'd7,
		M_IND = 4'd8,
		M_IZX = 4'd9,
		M_IZY = 4'd10,
		M_REL = 4'd11
	} mode_t;

	localparam logic IN_START = 1'b0;
	localparam logic IN_DATA  = 1'b1;

	// sequencer: idle, then one state per operand byte still expected
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_S1   = 5'b00010,
		ST_S2   = 5'b00100,
		ST_S3   = 5'b01000,
		ST_S4   = 5'b10000
	} state_t;

endpackage

@@ design/cpu6502_address_mode_unit_top.sv @@
// A result word is registered: it appears in the cycle after its input word is accepted.
// One input word per cycle while the result side takes its words; each input word gives exactly one result word.
// A waiting result holds the input off; the next input word is taken in the cycle
// the result register is taken, or at once while that register is empty.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending.
module cpu6502_address_mode_unit_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// mode[3:0] pc[19:4] x_index[27:20] y_index[35:28] read_data[43:36] zero[47:44]
	input  logic [amu_pkg::InDataW-1:0]     s_tdata,
	// kind[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_addr[15:0] eff_addr[31:16] new_pc[47:32]
	output logic [amu_pkg::OutDataW-1:0]    m_tdata,
	// result_kind[1:0]
	output logic [amu_pkg::KindW-1:0]       m_tuser
);
	import amu_pkg::*;

	logic [ModeW-1:0] in_mode;
	logic [AddrW-1:0] in_pc;
	logic [ByteW-1:0] in_x;
	logic [ByteW-1:0] in_y;
	logic [ByteW-1:0] in_b;
	logic             in_fire;

	state_t           state_q, nxt_state;
	logic [ModeW-1:0] mode_q;
	logic [AddrW-1:0] pc_q;
	logic [ByteW-1:0] x_q;
	logic [ByteW-1:0] y_q;
	logic [AddrW-1:0] ptr_q, ptr_d;
	logic [ByteW-1:0] held_q;
	logic             ld_held, ld_ptr;

	result_kind_t     nxt_kind;
	logic [AddrW-1:0] nxt_raddr, nxt_eff, nxt_npc;
	logic [AddrW-1:0] pc1, pc2, word;
	logic [ByteW-1:0] ptr_lo_inc;

	logic             m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;
	result_kind_t     m_kind_q;

	assign in_mode = s_tdata[3:0];
	assign in_pc   = s_tdata[19:4];
	assign in_x    = s_tdata[27:20];
	assign in_y    = s_tdata[35:28];
	assign in_b    = s_tdata[43:36];

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	assign pc1        = pc_q + AddrW'(1);
	assign pc2        = pc_q + AddrW'(2);
	assign word       = {in_b, held_q};
	assign ptr_lo_inc = ptr_q[ByteW-1:0] + ByteW'(1);

	always_comb begin
		nxt_kind  = RK_IGNORED;
		nxt_raddr = '0;
		nxt_eff   = '0;
		nxt_npc   = '0;
		nxt_state = state_q;
		ld_held   = 1'b0;
		ld_ptr    = 1'b0;
		ptr_d     = word;
		if (s_tuser == IN_START) begin
			if (in_mode == M_IMM) begin
				nxt_kind  = RK_DONE;
				nxt_eff   = in_pc;
				nxt_npc   = in_pc + AddrW'(1);
				nxt_state = ST_IDLE;
			end else if (in_mode == M_IMP || in_mode > M_REL) begin
				nxt_kind  = RK_DONE;
				nxt_npc   = in_pc;
				nxt_state = ST_IDLE;
			end else begin
				nxt_kind  = RK_READ;
				nxt_raddr = in_pc;
				nxt_state = ST_S1;
			end
		end else if (state_q != ST_IDLE) begin
			nxt_state = ST_IDLE;
			case (mode_q)
				M_ZP: begin
					nxt_kind = RK_DONE;
					nxt_eff  = {8'h00, in_b};
					nxt_npc  = pc1;
				end
				M_ZPX: begin
					nxt_kind = RK_DONE;
					nxt_eff  = {8'h00, ByteW'(in_b + x_q)};
					nxt_npc  = pc1;
				end
				M_ZPY: begin
					nxt_kind = RK_DONE;
					nxt_eff  = {8'h00, ByteW'(in_b + y_q)};
					nxt_npc  = pc1;
				end
				M_REL: begin
					nxt_kind = RK_DONE;
					nxt_eff  = pc1 + {{8{in_b[7]}}, in_b};
					nxt_npc  = pc1;
				end
				M_ABS, M_ABX, M_ABY, M_IND: begin
					if (state_q == ST_S1) begin
						ld_held   = 1'b1;
						nxt_kind  = RK_READ;
						nxt_raddr = pc1;
						nxt_state = ST_S2;
					end else if (state_q == ST_S2) begin
						nxt_npc = pc2;
						if (mode_q == M_IND) begin
							ld_ptr    = 1'b1;
							nxt_kind  = RK_READ;
							nxt_raddr = word;
							nxt_npc   = '0;
							nxt_state = ST_S3;
						end else if (mode_q == M_ABX) begin
							nxt_kind = RK_DONE;
							nxt_eff  = word + {8'h00, x_q};
						end else if (mode_q == M_ABY) begin
							nxt_kind = RK_DONE;
							nxt_eff  = word + {8'h00, y_q};
						end else begin
							nxt_kind = RK_DONE;
							nxt_eff  = word;
						end
					end else if (state_q == ST_S3 && mode_q == M_IND) begin
						// page-wrap bug: high byte from the same page
						ld_held   = 1'b1;
						nxt_kind  = RK_READ;
						nxt_raddr = {ptr_q[AddrW-1:ByteW], ptr_lo_inc};
						nxt_state = ST_S4;
					end else if (state_q == ST_S4 && mode_q == M_IND) begin
						nxt_kind = RK_DONE;
						nxt_eff  = word;
						nxt_npc  = pc2;
					end
				end
				M_IZX, M_IZY: begin
					if (state_q == ST_S1) begin
						ld_ptr    = 1'b1;
						ptr_d     = {8'h00, (mode_q == M_IZX) ? ByteW'(in_b + x_q) : in_b};
						nxt_kind  = RK_READ;
						nxt_raddr = ptr_d;
						nxt_state = ST_S2;
					end else if (state_q == ST_S2) begin
						ld_held   = 1'b1;
						nxt_kind  = RK_READ;
						nxt_raddr = {8'h00, ptr_lo_inc};
						nxt_state = ST_S3;
					end else if (state_q == ST_S3) begin
						nxt_kind = RK_DONE;
						nxt_eff  = (mode_q == M_IZY) ? word + {8'h00, y_q} : word;
						nxt_npc  = pc1;
					end
				end
				default: begin
					nxt_kind = RK_IGNORED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= in_fire || (m_tvalid_q && !m_tready);
			if (in_fire) begin
				state_q <= nxt_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (s_tuser == IN_START) begin
				mode_q <= in_mode;
				pc_q   <= in_pc;
				x_q    <= in_x;
				y_q    <= in_y;
			end
			if (ld_held) begin
				held_q <= in_b;
			end
			if (ld_ptr) begin
				ptr_q <= ptr_d;
			end
			m_tdata_q <= {nxt_npc, nxt_eff, nxt_raddr};
			m_kind_q  <= nxt_kind;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_kind_q;

	a_imm_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == IN_START && in_mode == M_IMM
		|=> m_tvalid && m_tuser == RK_DONE && m_tdata[31:16] == $past(in_pc))
		else $error("immediate start did not finish at once");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && nxt_kind == RK_DONE |=> state_q == ST_IDLE)
		else $error("sequencer busy after done result");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && nxt_kind == RK_READ |=> state_q != ST_IDLE)
		else $error("sequencer idle after read request");

	a_idle_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == IN_DATA && state_q == ST_IDLE
		|=> state_q == ST_IDLE && m_tuser == RK_IGNORED)
		else $error("data while idle not ignored");

	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == RK_READ || m_tuser == RK_DONE || m_tuser == RK_IGNORED)
		else $error("bad result kind");

endmodule

@@ test/tb_top.sv @@
module tb_top;
	import amu_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [3:0] mode;
		logic [15:0] pc;
		logic [7:0] x_index;
		logic [7:0] y_index;
		logic [7:0] read_data;
	} in_word_t;

	typedef struct packed {
		result_kind_t kind;
		logic [15:0]  read_addr;
		logic [15:0]  eff_addr;
		logic [15:0]  new_pc;
	} addr_result_t;

	localparam int ITEM_COUNT     = 1200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT        = 300;
	localparam int DRAIN_AT       = 600;
	localparam int TAIL_CYCLES    = 10;

	// Address-mode predictor plus queue of expected result words.
	class addr_scoreboard;
		logic        busy;
		logic [3:0]  cur_mode;
		logic [2:0]  step;
		logic [15:0] saved_pc;
		logic [7:0]  saved_x;
		logic [7:0]  saved_y;
		logic [15:0] pointer;
		logic [7:0]  held_byte;
		addr_result_t expected_q[$];
		int          errors;

		function new();
			busy      = 1'b0;
			cur_mode  = '0;
			step      = '0;
			saved_pc  = '0;
			saved_x   = '0;
			saved_y   = '0;
			pointer   = '0;
			held_byte = '0;
			errors    = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function addr_result_t read_req(logic [15:0] addr, logic [2:0] next_step);
			addr_result_t r;
			step        = next_step;
			r.kind      = RK_READ;
			r.read_addr = addr;
			r.eff_addr  = '0;
			r.new_pc    = '0;
			return r;
		endfunction

		function addr_result_t done(logic [15:0] eff, logic [15:0] operand_len);
			addr_result_t r;
			busy        = 1'b0;
			step        = '0;
			r.kind      = RK_DONE;
			r.read_addr = '0;
			r.eff_addr  = eff;
			r.new_pc    = saved_pc + operand_len;
			return r;
		endfunction

		function addr_result_t ignored(logic drop);
			addr_result_t r;
			if (drop) begin
				busy = 1'b0;
				step = '0;
			end
			r.kind      = RK_IGNORED;
			r.read_addr = '0;
			r.eff_addr  = '0;
			r.new_pc    = '0;
			return r;
		endfunction

		function addr_result_t predict(in_word_t w);
			logic [7:0]  b;
			logic [7:0]  zsum;
			logic [15:0] word;
			logic [15:0] offset;
			if (w.kind == IN_START) begin
				cur_mode = w.mode;
				saved_pc = w.pc;
				saved_x  = w.x_index;
				saved_y  = w.y_index;
				busy     = 1'b1;
				step     = '0;
				if (cur_mode == M_IMM)
					return done(saved_pc, 16'd1);
				if (cur_mode == M_IMP || cur_mode > M_REL)
					return done(16'h0000, 16'd0);
				return read_req(saved_pc, 3'd1);
			end
			if (!busy)
				return ignored(1'b0);
			b    = w.read_data;
			word = {b, held_byte};
			case (cur_mode)
				M_ZP: begin
					return done({8'h00, b}, 16'd1);
				end
				M_ZPX: begin
					zsum = b + saved_x;
					return done({8'h00, zsum}, 16'd1);
				end
				M_ZPY: begin
					zsum = b + saved_y;
					return done({8'h00, zsum}, 16'd1);
				end
				M_REL: begin
					offset = {{8{b[7]}}, b};
					return done(saved_pc + 16'd1 + offset, 16'd1);
				end
				M_ABS, M_ABX, M_ABY, M_IND: begin
					if (step == 3'd1) begin
						held_byte = b;
						return read_req(saved_pc + 16'd1, 3'd2);
					end
					if (step == 3'd2) begin
						if (cur_mode == M_ABS)
							return done(word, 16'd2);
						if (cur_mode == M_ABX)
							return done(word + {8'h00, saved_x}, 16'd2);
						if (cur_mode == M_ABY)
							return done(word + {8'h00, saved_y}, 16'd2);
						pointer = word;
						return read_req(pointer, 3'd3);
					end
					// indirect keeps the page-wrap bug on the high byte fetch
					if (step == 3'd3 && cur_mode == M_IND) begin
						held_byte = b;
						zsum      = pointer[7:0] + 8'd1;
						return read_req({pointer[15:8], zsum}, 3'd4);
					end
					if (step == 3'd4 && cur_mode == M_IND)
						return done(word, 16'd2);
					return ignored(1'b1);
				end
				M_IZX, M_IZY: begin
					if (step == 3'd1) begin
						zsum    = (cur_mode == M_IZX) ? b + saved_x : b;
						pointer = {8'h00, zsum};
						return read_req(pointer, 3'd2);
					end
					if (step == 3'd2) begin
						held_byte = b;
						zsum      = pointer[7:0] + 8'd1;
						return read_req({8'h00, zsum}, 3'd3);
					end
					if (step == 3'd3) begin
						if (cur_mode == M_IZX)
							return done(word, 16'd1);
						return done(word + {8'h00, saved_y}, 16'd1);
					end
					return ignored(1'b1);
				end
				default: begin
					return ignored(1'b1);
				end
			endcase
		endfunction

		function void note_input(in_word_t w);
			expected_q.push_back(predict(w));
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check(logic [KindW-1:0] kind, logic [OutDataW-1:0] data);
			addr_result_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("result word with nothing pending: kind %0d data %h", kind, data));
				return;
			end
			exp = expected_q.pop_front();
			if (kind != exp.kind)
				report($sformatf("result_kind %0d, want %0d", kind, exp.kind));
			if (data[15:0] != exp.read_addr)
				report($sformatf("read_addr %h, want %h", data[15:0], exp.read_addr));
			if (data[31:16] != exp.eff_addr)
				report($sformatf("eff_addr %h, want %h", data[31:16], exp.eff_addr));
			if (data[47:32] != exp.new_pc)
				report($sformatf("new_pc %h, want %h", data[47:32], exp.new_pc));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [InDataW-1:0]    s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OutDataW-1:0]   m_tdata;
	logic [KindW-1:0]      m_tuser;

	addr_scoreboard sb = new();
	int             n_sent = 0;
	bit             no_idle = 1'b0;

	cpu6502_address_mode_unit_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 6))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom), 8'hFF};
			3: return {8'($urandom), 8'h00};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int operand_reads(logic [3:0] mode);
		case (mode)
			M_ZP, M_ZPX, M_ZPY, M_REL: return 1;
			M_ABS, M_ABX, M_ABY:       return 2;
			M_IZX, M_IZY:              return 3;
			M_IND:                     return 4;
			default:                   return 0;
		endcase
	endfunction

	function automatic in_word_t start_word(logic [3:0] mode);
		in_word_t w;
		w.kind      = IN_START;
		w.mode      = mode;
		w.pc        = pick_addr();
		w.x_index   = pick_byte();
		w.y_index   = pick_byte();
		w.read_data = 8'($urandom);
		return w;
	endfunction

	function automatic in_word_t data_word();
		in_word_t w;
		w.kind      = IN_DATA;
		w.mode      = 4'($urandom);
		w.pc        = 16'($urandom);
		w.x_index   = 8'($urandom);
		w.y_index   = 8'($urandom);
		w.read_data = pick_byte();
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		no_idle = ((n_sent / 150) % 4 == 3);
		gap     = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= w.kind;
		s_tdata  <= {4'h0, w.read_data, w.y_index, w.x_index, w.pc, w.mode};
		do @(posedge clk); while (!s_tready);
		sb.note_input(w);
		n_sent++;
	endtask

	task automatic fixed_seq(input logic [3:0] mode, input logic [15:0] pc,
		input logic [7:0] xi, input logic [7:0] yi, input logic [31:0] bytes, input int count);
		in_word_t w;
		w = '{IN_START, mode, pc, xi, yi, 8'h00};
		send_word(w);
		for (int i = 0; i < count; i++) begin
			w.kind      = IN_DATA;
			w.read_data = bytes[8*i +: 8];
			send_word(w);
		end
	endtask

	task automatic random_seq(input logic [3:0] mode, input int count);
		send_word(start_word(mode));
		repeat (count) send_word(data_word());
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int         sel;
		logic [3:0] m;
		bit         drained;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		drained  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data while idle, then every mode at its wrap corners
		send_word('{IN_DATA, 4'hF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
		fixed_seq(M_IMP, 16'hFFFF, 8'h00, 8'h00, 32'h0, 0);
		fixed_seq(M_IMM, 16'hFFFF, 8'hFF, 8'hFF, 32'h0, 0);
		fixed_seq(4'hF, 16'h8000, 8'h12, 8'h34, 32'h0, 0);
		fixed_seq(M_ZP, 16'h1234, 8'h00, 8'h00, 32'h0000_00FF, 1);
		fixed_seq(M_ZPX, 16'h0000, 8'hFF, 8'h00, 32'h0000_0080, 1);
		fixed_seq(M_ZPY, 16'h7FFF, 8'h00, 8'h01, 32'h0000_00FF, 1);
		fixed_seq(M_REL, 16'hFFFF, 8'h00, 8'h00, 32'h0000_0080, 1);
		fixed_seq(M_REL, 16'hFFFE, 8'h00, 8'h00, 32'h0000_007F, 1);
		fixed_seq(M_ABS, 16'hFFFF, 8'h00, 8'h00, 32'h0000_FF00, 2);
		fixed_seq(M_ABX, 16'h4000, 8'hFF, 8'h00, 32'h0000_FFFF, 2);
		// aby cut short: the next start lands while busy
		fixed_seq(M_ABY, 16'h2000, 8'h00, 8'hFF, 32'h0000_0010, 1);
		fixed_seq(M_IND, 16'h4000, 8'h00, 8'h00, 32'h5634_12FF, 4);
		fixed_seq(M_IZX, 16'h0300, 8'h7F, 8'h00, 32'h0022_1180, 3);
		fixed_seq(M_IZY, 16'h0600, 8'h00, 8'hFF, 32'h00FF_FFFF, 3);

		while (n_sent < ITEM_COUNT) begin
			if (!drained && n_sent >= DRAIN_AT) begin
				drained = 1'b1;
				wait_drained();
			end
			sel = $urandom_range(0, 99);
			m   = 4'($urandom_range(0, 11));
			if (sel < 80) begin
				random_seq(m, operand_reads(m));
			end else if (sel < 92) begin
				m = 4'($urandom);
				random_seq(m, $urandom_range(0, operand_reads(m) + 1));
			end else begin
				send_word(data_word());
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("cpu6502_address_mode_unit_top test passed");
		else
			$display("cpu6502_address_mode_unit_top test failed");
		$finish;
	end

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int stall;
		int n_results;
		bit held;
		stall     = 0;
		n_results = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check(m_tuser, m_tdata);
				n_results++;
				if (!held && n_results >= HOLD_AT) begin
					held  = 1'b1;
					stall = HOLD_CYCLES;
				end
			end
			if (stall == 0 && !no_idle && $urandom_range(0, 3) == 0)
				stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("cpu6502_address_mode_unit_top test failed");
		$finish;
	end

endmodule
